// ===== sv/tcw_pkg.sv =====
// Shared types, codes and constants of the text console writer.
package tcw_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // One cell: attribute in the high byte, character in the low byte.
  localparam int CELL_W = 16;

  localparam logic [7:0] BLANK_CHAR  = 8'h20;
  localparam logic [7:0] RESET_ATTR  = 8'h07;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic       CURSOR_EN_RESET = 1'b1;

  // Request modes as they arrive on the input channel.
  localparam logic [2:0] MODE_PUT   = 3'd0;
  localparam logic [2:0] MODE_LEFT  = 3'd1;
  localparam logic [2:0] MODE_RIGHT = 3'd2;
  localparam logic [2:0] MODE_CLEAR = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  // Register index, taken from paddr bit 2.
  localparam logic REG_TEXT_ATTR = 1'b0;
  localparam logic REG_CURSOR_EN = 1'b1;

  // Entries in the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Operations after classification by the front.
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_LEFT,
    OP_RIGHT,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_RESP
  } state_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] ch,
                                                  input logic [7:0] attr);
    return {attr, ch};
  endfunction

endpackage

// ===== sv/tcw_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module tcw_ram #(
  parameter int WIDTH = tcw_pkg::CELL_W,
  parameter int DEPTH = tcw_pkg::ROWS_DEF * tcw_pkg::COLUMNS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tcw_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
module tcw_front #(
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    in_mode,
  input  logic [7:0]    in_char_code,
  input  logic [4:0]    in_read_row,
  input  logic [6:0]    in_read_col,
  input  logic          init_done,
  output logic          q_valid,
  output tcw_pkg::cmd_t q_cmd,
  input  logic          q_pop
);

  localparam int PTR_W = $clog2(tcw_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

  tcw_pkg::cmd_t    cmd_in;
  tcw_pkg::cmd_t    cmd_q_r [tcw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             row_ok;
  logic             col_ok;

  // A read outside the screen changes nothing, so it becomes a no-op.
  assign row_ok = ({2'b00, in_read_row} < 7'(ROWS));
  assign col_ok = ({1'b0, in_read_col} < 8'(COLUMNS));

  // Classify the request.
  always_comb begin
    cmd_in.op  = tcw_pkg::OP_NOP;
    cmd_in.ch  = in_char_code;
    cmd_in.row = in_read_row;
    cmd_in.col = in_read_col;
    unique case (in_mode)
      tcw_pkg::MODE_PUT: begin
        if (in_char_code == tcw_pkg::CHAR_LF || in_char_code == tcw_pkg::CHAR_CR) begin
          cmd_in.op = tcw_pkg::OP_NEWLINE;
        end else begin
          cmd_in.op = tcw_pkg::OP_PUT;
        end
      end
      tcw_pkg::MODE_LEFT:  cmd_in.op = tcw_pkg::OP_LEFT;
      tcw_pkg::MODE_RIGHT: cmd_in.op = tcw_pkg::OP_RIGHT;
      tcw_pkg::MODE_CLEAR: cmd_in.op = tcw_pkg::OP_CLEAR;
      tcw_pkg::MODE_READ: begin
        if (row_ok && col_ok) begin
          cmd_in.op = tcw_pkg::OP_READ;
        end
      end
      default: cmd_in.op = tcw_pkg::OP_NOP;
    endcase
  end

  // Hold requests off while the store is being cleared after reset or the queue is full.
  assign busy = !init_done || (count_r == CNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign push = start && !busy;

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = push  ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (q_pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign q_valid = (count_r != '0);
  assign q_cmd   = cmd_q_r[rd_ptr_r];

endmodule

// ===== sv/tcw_back.sv =====
// Back end: cursor, cell store and the sequencer that carries out each request.
module tcw_back #(
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    text_attr,
  input  logic          cursor_en,
  input  logic          q_valid,
  input  tcw_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          init_done,
  output logic          out_valid,
  output logic [10:0]   out_cursor_position,
  output logic [6:0]    out_cursor_col,
  output logic [4:0]    out_cursor_row,
  output logic [7:0]    out_cell_char,
  output logic [7:0]    out_cell_attr,
  output logic          out_scrolled
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int LINE_W = $clog2(ROWS);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [LINE_W-1:0] LAST_LINE  = LINE_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);

  tcw_pkg::state_t state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [ADDR_W-1:0] shown_r, shown_nxt;
  logic              upd_r, upd_nxt;
  logic              scr_r, scr_nxt;
  logic              rd_r, rd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [10:0]       out_pos_r, out_pos_nxt;
  logic [6:0]        out_col_r, out_col_nxt;
  logic [4:0]        out_row_r, out_row_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic [7:0]        out_attr_r, out_attr_nxt;
  logic              out_scr_r, out_scr_nxt;

  logic                       dispatch;
  logic                       sel_read;
  logic [ADDR_W-1:0]          mul_row;
  logic [ADDR_W-1:0]          mul_col;
  logic [ADDR_W-1:0]          lin_addr;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign dispatch  = (state_r == tcw_pkg::ST_IDLE) && q_valid;
  assign init_done = (state_r != tcw_pkg::ST_INIT);
  assign q_pop     = dispatch;

  // Linear cell address: the read cell while dispatching a read, else the cursor.
  assign sel_read = dispatch && (q_cmd.op == tcw_pkg::OP_READ);
  assign mul_row  = sel_read ? ADDR_W'(q_cmd.row) : ADDR_W'(line_r);
  assign mul_col  = sel_read ? ADDR_W'(q_cmd.col) : ADDR_W'(col_r);
  assign lin_addr = ADDR_W'(ADDR_W'(mul_row * ROW_STEP) + mul_col);

  // Sweep counter wraps to zero after the last cell.
  assign cnt_inc = (cnt_r == LAST_CELL) ? '0 : ADDR_W'(cnt_r + 1'b1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        if (cnt_r == LAST_CELL) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            tcw_pkg::OP_PUT: begin
              if (col_r == LAST_COL && line_r == LAST_LINE) begin
                state_nxt = tcw_pkg::ST_SCROLL;
              end else begin
                state_nxt = tcw_pkg::ST_RESP;
              end
            end
            tcw_pkg::OP_NEWLINE: begin
              if (line_r == LAST_LINE) begin
                state_nxt = tcw_pkg::ST_SCROLL;
              end else begin
                state_nxt = tcw_pkg::ST_RESP;
              end
            end
            tcw_pkg::OP_CLEAR: state_nxt = tcw_pkg::ST_CLEAR;
            default:           state_nxt = tcw_pkg::ST_RESP;
          endcase
        end
      end
      tcw_pkg::ST_SCROLL: begin
        if (cnt_r == SCROLL_END) begin
          state_nxt = tcw_pkg::ST_BLANK;
        end
      end
      tcw_pkg::ST_BLANK, tcw_pkg::ST_CLEAR: begin
        if (cnt_r == LAST_CELL) begin
          state_nxt = tcw_pkg::ST_RESP;
        end
      end
      tcw_pkg::ST_RESP: state_nxt = tcw_pkg::ST_IDLE;
      default:          state_nxt = tcw_pkg::ST_IDLE;
    endcase
  end

  // Datapath, store accesses and result.
  always_comb begin
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    shown_nxt     = shown_r;
    upd_nxt       = upd_r;
    scr_nxt       = scr_r;
    rd_nxt        = rd_r;
    out_valid_nxt = 1'b0;
    out_pos_nxt   = out_pos_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    out_scr_nxt   = out_scr_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = tcw_pkg::make_cell(tcw_pkg::BLANK_CHAR, text_attr);
    ram_re        = 1'b0;
    ram_raddr     = lin_addr;
    unique case (state_r)
      // Fill the store with blanks of the reset attribute.
      tcw_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::make_cell(tcw_pkg::BLANK_CHAR, tcw_pkg::RESET_ATTR);
        cnt_nxt   = cnt_inc;
      end
      // Take one request, write its character for a put, and update the cursor or start a read.
      tcw_pkg::ST_IDLE: begin
        if (q_valid) begin
          upd_nxt = 1'b0;
          scr_nxt = 1'b0;
          rd_nxt  = 1'b0;
          cnt_nxt = '0;
          unique case (q_cmd.op)
            tcw_pkg::OP_PUT: begin
              ram_we    = 1'b1;
              ram_waddr = lin_addr;
              ram_wdata = tcw_pkg::make_cell(q_cmd.ch, text_attr);
              upd_nxt   = cursor_en;
              if (col_r == LAST_COL) begin
                col_nxt = '0;
                if (line_r == LAST_LINE) begin
                  scr_nxt = 1'b1;
                end else begin
                  line_nxt = LINE_W'(line_r + 1'b1);
                end
              end else begin
                col_nxt = COL_W'(col_r + 1'b1);
              end
            end
            tcw_pkg::OP_NEWLINE: begin
              upd_nxt = cursor_en;
              col_nxt = '0;
              if (line_r == LAST_LINE) begin
                scr_nxt = 1'b1;
              end else begin
                line_nxt = LINE_W'(line_r + 1'b1);
              end
            end
            tcw_pkg::OP_LEFT: begin
              upd_nxt = 1'b1;
              if (col_r == '0) begin
                if (line_r != '0) begin
                  col_nxt  = LAST_COL;
                  line_nxt = LINE_W'(line_r - 1'b1);
                end
              end else begin
                col_nxt = COL_W'(col_r - 1'b1);
              end
            end
            tcw_pkg::OP_RIGHT: begin
              upd_nxt = 1'b1;
              if (col_r == LAST_COL) begin
                if (line_r != LAST_LINE) begin
                  col_nxt  = '0;
                  line_nxt = LINE_W'(line_r + 1'b1);
                end
              end else begin
                col_nxt = COL_W'(col_r + 1'b1);
              end
            end
            tcw_pkg::OP_CLEAR: begin
              upd_nxt  = cursor_en;
              col_nxt  = '0;
              line_nxt = '0;
            end
            tcw_pkg::OP_READ: begin
              ram_re = 1'b1;
              rd_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      // Copy each cell up one row: read one row below, write the cell read last cycle.
      tcw_pkg::ST_SCROLL: begin
        ram_re    = (cnt_r != SCROLL_END);
        ram_raddr = ADDR_W'(cnt_r + ROW_STEP);
        ram_we    = (cnt_r != '0);
        ram_waddr = ADDR_W'(cnt_r - 1'b1);
        ram_wdata = ram_rdata;
        cnt_nxt   = (cnt_r == SCROLL_END) ? cnt_r : ADDR_W'(cnt_r + 1'b1);
      end
      // Blank the bottom row, or the whole screen for a clear.
      tcw_pkg::ST_BLANK, tcw_pkg::ST_CLEAR: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_inc;
      end
      // Send the cursor on if asked and present the result.
      tcw_pkg::ST_RESP: begin
        if (upd_r) begin
          shown_nxt = lin_addr;
        end
        out_valid_nxt = 1'b1;
        out_pos_nxt   = 11'(shown_nxt);
        out_col_nxt   = 7'(col_r);
        out_row_nxt   = 5'(line_r);
        out_char_nxt  = rd_r ? ram_rdata[7:0] : 8'h00;
        out_attr_nxt  = rd_r ? ram_rdata[15:8] : 8'h00;
        out_scr_nxt   = scr_r;
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_INIT;
      cnt_r       <= '0;
      col_r       <= '0;
      line_r      <= '0;
      shown_r     <= '0;
      upd_r       <= 1'b0;
      scr_r       <= 1'b0;
      rd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      shown_r     <= shown_nxt;
      upd_r       <= upd_nxt;
      scr_r       <= scr_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_pos_r  <= out_pos_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_pos_r;
  assign out_cursor_col      = out_col_r;
  assign out_cursor_row      = out_row_r;
  assign out_cell_char       = out_char_r;
  assign out_cell_attr       = out_attr_r;
  assign out_scrolled        = out_scr_r;

  // Results never come in consecutive cycles.
  a_resp_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // The cursor stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= LAST_COL) && (line_r <= LAST_LINE))
    else $error("cursor left the screen");

  // Every store write lands inside the screen.
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_waddr <= LAST_CELL))
    else $error("store write out of range");

  // A scroll always leaves the cursor at the start of a line.
  a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_scrolled) |-> (out_cursor_col == 7'd0))
    else $error("scroll left the cursor off column zero");

  // No request is taken before the store has been cleared after reset.
  a_pop_after_init: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && init_done))
    else $error("request taken during the clearing pass");

endmodule

// ===== sv/text_console_writer_top.sv =====
// Top level of the text console writer: register port, front end and back end.
//
//  Channel   Direction  Handshake                     Payload
//  input     in         start & !busy                 in_mode, in_char_code, in_read_row,
//                                                     in_read_col
//  result    out        out_valid, one cycle          out_cursor_position, out_cursor_col,
//                                                     out_cursor_row, out_cell_char,
//                                                     out_cell_attr, out_scrolled
//  config    in/out     psel & penable & pwrite       paddr, pwdata, prdata, pready
//
// A request goes through the request queue, then the idle and response states of the sequencer, then
// the result registers, before its result is on the out_ ports. The back end carries out one request
// at a time and takes the next only from its idle state. A scroll runs a copy pass, then blanks the
// bottom row, through the single write port of the cell store; a clear screen blanks every cell.
// After reset a clearing pass fills the store with blanks; busy is high throughout, while register
// writes are taken as usual.
// Busy is high while the two-entry request queue is full; results cannot be held off.
module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  // Result channel
  output logic        out_valid,
  output logic [10:0] out_cursor_position,
  output logic [6:0]  out_cursor_col,
  output logic [4:0]  out_cursor_row,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_attr,
  output logic        out_scrolled,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]    text_attr_r, text_attr_nxt;
  logic          cursor_en_r, cursor_en_nxt;
  logic          reg_wr;
  logic          init_done;
  logic          q_valid;
  logic          q_pop;
  tcw_pkg::cmd_t q_cmd;

  // Register writes complete in the access phase.
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_comb begin
    text_attr_nxt = text_attr_r;
    cursor_en_nxt = cursor_en_r;
    if (reg_wr) begin
      unique case (paddr[2])
        tcw_pkg::REG_TEXT_ATTR: text_attr_nxt = pwdata[7:0];
        tcw_pkg::REG_CURSOR_EN: cursor_en_nxt = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= tcw_pkg::RESET_ATTR;
      cursor_en_r <= tcw_pkg::CURSOR_EN_RESET;
    end else begin
      text_attr_r <= text_attr_nxt;
      cursor_en_r <= cursor_en_nxt;
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      tcw_pkg::REG_TEXT_ATTR: prdata = {24'h0, text_attr_r};
      tcw_pkg::REG_CURSOR_EN: prdata = {31'h0, cursor_en_r};
      default:                prdata = 32'h0;
    endcase
  end

  tcw_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_char_code (in_char_code),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .init_done    (init_done),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  tcw_back #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .text_attr           (text_attr_r),
    .cursor_en           (cursor_en_r),
    .q_valid             (q_valid),
    .q_cmd               (q_cmd),
    .q_pop               (q_pop),
    .init_done           (init_done),
    .out_valid           (out_valid),
    .out_cursor_position (out_cursor_position),
    .out_cursor_col      (out_cursor_col),
    .out_cursor_row      (out_cursor_row),
    .out_cell_char       (out_cell_char),
    .out_cell_attr       (out_cell_attr),
    .out_scrolled        (out_scrolled)
  );

endmodule

// ===== sim/text_console_checker.sv =====
`timescale 1ns / 1ps
// Checker for the text console writer: predicts each result from the requests and registers seen.
module text_console_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  input  logic        out_valid,
  input  logic [10:0] out_cursor_position,
  input  logic [6:0]  out_cursor_col,
  input  logic [4:0]  out_cursor_row,
  input  logic [7:0]  out_cell_char,
  input  logic [7:0]  out_cell_attr,
  input  logic        out_scrolled,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          error_count,
  output int          pending
);

  localparam int CELLS = ROWS * COLUMNS;

  typedef struct packed {
    logic [10:0] position;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        scrolled;
  } console_result_t;

  // Shadow copy of the screen, cursor and registers.
  logic [15:0]     screen_cells [CELLS];
  int              cur_col;
  int              cur_row;
  int              shown_pos;
  logic [7:0]      attr_reg;
  logic            cursor_follow;
  console_result_t expected_results [$];
  int              requests_taken;
  int              results_matched;

  assign pending = requests_taken - results_matched;

  // Start of the next line; scrolls everything up a row when it runs off the bottom.
  function automatic logic advance_line();
    cur_col = 0;
    cur_row++;
    if (cur_row < ROWS) begin
      return 1'b0;
    end
    for (int i = 0; i < CELLS - COLUMNS; i++) begin
      screen_cells[i] = screen_cells[i + COLUMNS];
    end
    for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
      screen_cells[i] = {attr_reg, tcw_pkg::BLANK_CHAR};
    end
    cur_row = ROWS - 1;
    return 1'b1;
  endfunction

  // Applies one request to the shadow state and returns the result it should produce.
  function automatic console_result_t apply_request(input logic [2:0] mode,
                                                    input logic [7:0] ch,
                                                    input logic [4:0] rrow,
                                                    input logic [6:0] rcol);
    console_result_t res;
    res = '0;
    case (mode)
      tcw_pkg::MODE_PUT: begin
        if (ch == tcw_pkg::CHAR_LF || ch == tcw_pkg::CHAR_CR) begin
          res.scrolled = advance_line();
        end else begin
          screen_cells[cur_row * COLUMNS + cur_col] = {attr_reg, ch};
          cur_col++;
          if (cur_col >= COLUMNS) begin
            res.scrolled = advance_line();
          end
        end
        if (cursor_follow) begin
          shown_pos = cur_row * COLUMNS + cur_col;
        end
      end
      tcw_pkg::MODE_LEFT: begin
        // Wraps to the end of the row above; stays put at the top-left corner.
        if (cur_col != 0) begin
          cur_col--;
        end else if (cur_row != 0) begin
          cur_col = COLUMNS - 1;
          cur_row--;
        end
        shown_pos = cur_row * COLUMNS + cur_col;
      end
      tcw_pkg::MODE_RIGHT: begin
        // Wraps to the start of the row below; stays put at the bottom-right corner.
        if (cur_col != COLUMNS - 1) begin
          cur_col++;
        end else if (cur_row != ROWS - 1) begin
          cur_col = 0;
          cur_row++;
        end
        shown_pos = cur_row * COLUMNS + cur_col;
      end
      tcw_pkg::MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          screen_cells[i] = {attr_reg, tcw_pkg::BLANK_CHAR};
        end
        cur_col = 0;
        cur_row = 0;
        if (cursor_follow) begin
          shown_pos = 0;
        end
      end
      tcw_pkg::MODE_READ: begin
        // Cells off the screen read as zero.
        if (rrow < ROWS && rcol < COLUMNS) begin
          res.cell_char = screen_cells[rrow * COLUMNS + rcol][7:0];
          res.cell_attr = screen_cells[rrow * COLUMNS + rcol][15:8];
        end
      end
      default: begin
      end
    endcase
    res.position = shown_pos[10:0];
    res.col      = cur_col[6:0];
    res.row      = cur_row[4:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        screen_cells[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
      end
      cur_col         = 0;
      cur_row         = 0;
      shown_pos       = 0;
      attr_reg        = tcw_pkg::RESET_ATTR;
      cursor_follow   = tcw_pkg::CURSOR_EN_RESET;
      error_count     = 0;
      expected_results.delete();
      requests_taken  <= 0;
      results_matched <= 0;
    end else begin
      // Results are compared before this edge's request is added, as none can be that quick.
      if (out_valid === 1'b1) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with no request waiting, position %0d", $time,
                   out_cursor_position);
          error_count++;
        end else begin
          console_result_t want;
          want = expected_results.pop_front();
          results_matched <= results_matched + 1;
          check_field("cursor_position", 16'(want.position), 16'(out_cursor_position));
          check_field("cursor_col", 16'(want.col), 16'(out_cursor_col));
          check_field("cursor_row", 16'(want.row), 16'(out_cursor_row));
          check_field("cell_char", 16'(want.cell_char), 16'(out_cell_char));
          check_field("cell_attr", 16'(want.cell_attr), 16'(out_cell_attr));
          check_field("scrolled", 16'(want.scrolled), 16'(out_scrolled));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_results.push_back(apply_request(in_mode, in_char_code, in_read_row,
                                                 in_read_col));
        requests_taken <= requests_taken + 1;
      end
      // Register writes complete in the access cycle.
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == tcw_pkg::REG_TEXT_ATTR) begin
          attr_reg = pwdata[7:0];
        end else begin
          cursor_follow = pwdata[0];
        end
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the text console writer: clock, reset, stimulus and the verdict.
module tb_top;

  localparam int COLUMNS        = tcw_pkg::COLUMNS_DEF;
  localparam int ROWS           = tcw_pkg::ROWS_DEF;
  localparam int PHASE_REQUESTS = 206;
  localparam int CYCLE_LIMIT    = 8_000_000;
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        start        = 1'b0;
  logic [2:0]  in_mode      = '0;
  logic [7:0]  in_char_code = '0;
  logic [4:0]  in_read_row  = '0;
  logic [6:0]  in_read_col  = '0;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;

  logic        busy;
  logic        out_valid;
  logic [10:0] out_cursor_position;
  logic [6:0]  out_cursor_col;
  logic [4:0]  out_cursor_row;
  logic [7:0]  out_cell_char;
  logic [7:0]  out_cell_attr;
  logic        out_scrolled;
  logic [31:0] prdata;
  logic        pready;

  int error_count;
  int pending;
  int requests_sent = 0;
  int burst_left    = 0;
  int cycle_count   = 0;

  text_console_writer_top #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_mode(in_mode), .in_char_code(in_char_code),
    .in_read_row(in_read_row), .in_read_col(in_read_col),
    .out_valid(out_valid), .out_cursor_position(out_cursor_position),
    .out_cursor_col(out_cursor_col), .out_cursor_row(out_cursor_row),
    .out_cell_char(out_cell_char), .out_cell_attr(out_cell_attr),
    .out_scrolled(out_scrolled),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  text_console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_mode(in_mode), .in_char_code(in_char_code),
    .in_read_row(in_read_row), .in_read_col(in_read_col),
    .out_valid(out_valid), .out_cursor_position(out_cursor_position),
    .out_cursor_col(out_cursor_col), .out_cursor_row(out_cursor_row),
    .out_cell_char(out_cell_char), .out_cell_attr(out_cell_attr),
    .out_scrolled(out_scrolled),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .error_count(error_count), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly back-to-back or short gaps, now and then a long one, with idle-free bursts.
  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst_left = $urandom_range(20, 50);
      return 0;
    end else if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // Holds a request until it is taken, then idles for a random gap.
  task automatic send_request(input logic [2:0] mode, input logic [7:0] ch,
                              input logic [4:0] row, input logic [6:0] col);
    int gap;
    start        <= 1'b1;
    in_mode      <= mode;
    in_char_code <= ch;
    in_read_row  <= row;
    in_read_col  <= col;
    do @(posedge clk); while (busy !== 1'b0);
    requests_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_mode(input logic [2:0] mode);
    send_request(mode, 8'($urandom), 5'($urandom), 7'($urandom));
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_request(tcw_pkg::MODE_PUT, ch, 5'($urandom), 7'($urandom));
  endtask

  task automatic send_read(input logic [4:0] row, input logic [6:0] col);
    send_request(tcw_pkg::MODE_READ, 8'($urandom), row, col);
  endtask

  // A byte of any value except the two that start a new line.
  function automatic logic [7:0] any_glyph();
    logic [7:0] ch;
    do ch = 8'($urandom); while (ch == tcw_pkg::CHAR_LF || ch == tcw_pkg::CHAR_CR);
    return ch;
  endfunction

  function automatic logic [7:0] any_newline();
    return ($urandom_range(0, 1) == 0) ? tcw_pkg::CHAR_LF : tcw_pkg::CHAR_CR;
  endfunction

  // Stops sending and waits until every outstanding request has its result.
  task automatic finish_requests();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle, then idle.
  task automatic write_reg(input logic index, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Walks down to the bottom row, fills it, tests the corner and wraps off it.
  task automatic walk_to_corner();
    repeat (ROWS + $urandom_range(0, 2)) send_char(any_newline());
    repeat (COLUMNS - 1) send_char(any_glyph());
    send_mode(tcw_pkg::MODE_RIGHT);
    send_mode(tcw_pkg::MODE_RIGHT);
    send_mode(tcw_pkg::MODE_LEFT);
    send_mode(tcw_pkg::MODE_RIGHT);
    repeat (4) send_read(5'(ROWS - 1), 7'($urandom_range(0, COLUMNS - 1)));
    send_char(any_glyph());
    send_read(5'(ROWS - 2), 7'(COLUMNS - 1));
    send_read(5'(ROWS - 1), 7'($urandom_range(0, COLUMNS - 1)));
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if ($urandom_range(0, 9) == 0) begin
        send_char(any_newline());
      end else begin
        send_char(8'($urandom));
      end
    end else if (pick < 50) begin
      send_mode(tcw_pkg::MODE_LEFT);
    end else if (pick < 60) begin
      send_mode(tcw_pkg::MODE_RIGHT);
    end else if (pick < 62) begin
      send_mode(tcw_pkg::MODE_CLEAR);
    end else if (pick < 75) begin
      // Text piles up near the bottom after scrolling, so read there most.
      send_read(5'(ROWS - 1 - $urandom_range(0, 2)), 7'($urandom_range(0, COLUMNS - 1)));
    end else if (pick < 86) begin
      send_read(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
    end else if (pick < 95) begin
      send_read(5'($urandom), 7'($urandom));
    end else begin
      send_mode(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)));
    end
  endtask

  initial begin
    logic [7:0] attr_pick;
    logic       follow_pick;
    int         phase_base;
    int         walk_at;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // The store is blanked after reset; wait for that pass to end.
    do @(posedge clk); while (busy !== 1'b0);

    // Directed requests under the reset register values.
    send_read(5'd0, 7'd0);
    send_read(5'(ROWS - 1), 7'(COLUMNS - 1));
    send_read(5'h1F, 7'h7F);
    send_read(5'(ROWS), 7'd0);
    send_read(5'd0, 7'(COLUMNS));
    send_mode(tcw_pkg::MODE_LEFT);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(any_glyph());
    send_mode(MODE_SPARE_FIRST);
    send_mode(MODE_SPARE_LAST);
    send_read(5'd0, 7'd0);
    send_read(5'd0, 7'd1);
    send_char(tcw_pkg::CHAR_LF);
    send_mode(tcw_pkg::MODE_LEFT);
    send_mode(tcw_pkg::MODE_RIGHT);
    send_char(tcw_pkg::CHAR_CR);
    send_char(any_glyph());
    send_read(5'd2, 7'd0);
    send_mode(tcw_pkg::MODE_CLEAR);
    send_read(5'd0, 7'd1);
    send_mode(tcw_pkg::MODE_LEFT);
    finish_requests();

    // Phases under different register settings, extremes first.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          attr_pick   = 8'hFF;
          follow_pick = 1'b0;
        end
        1: begin
          attr_pick   = 8'h00;
          follow_pick = 1'b1;
        end
        default: begin
          attr_pick   = 8'($urandom);
          follow_pick = 1'($urandom);
        end
      endcase
      write_reg(tcw_pkg::REG_TEXT_ATTR, {24'h0, attr_pick});
      write_reg(tcw_pkg::REG_CURSOR_EN, {31'h0, follow_pick});
      phase_base = requests_sent;
      walk_at    = $urandom_range(0, 60);
      while (requests_sent - phase_base < PHASE_REQUESTS) begin
        if (requests_sent - phase_base == walk_at) begin
          walk_to_corner();
        end else begin
          random_request();
        end
      end
      finish_requests();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
